// ===== hw/rtl/dpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dpfr_pkg
// Shared constants, types and the microcode table of the distinct prime
// factor run block.
// ----------------------------------------------------------------------------
package dpfr_pkg;

	localparam int NUMBER_WIDTH  = 20;
	// trial divisor never exceeds floor(sqrt(number)) + 1
	localparam int DIV_WIDTH     = (NUMBER_WIDTH + 1) / 2 + 1;
	localparam int SQ_WIDTH      = 2 * DIV_WIDTH;
	localparam int BIT_CNT_WIDTH = $clog2(NUMBER_WIDTH + 1);
	localparam int PC_WIDTH      = 3;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [2:0] COUNT_MAX = 3'd7;
	localparam logic [3:0] RUN_MAX   = 4'd15;

	localparam logic [2:0] TARGET_RESET = 3'd4;
	localparam logic [3:0] RUN_RESET    = 4'd4;

	// register index, taken from paddr[2]
	localparam logic REG_TARGET     = 1'b0;
	localparam logic REG_RUN_NEEDED = 1'b1;

	typedef logic [PC_WIDTH-1:0] pc_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQUARE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_COMMIT,
		OP_NEXT_D,
		OP_FINISH
	} dp_op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NEVER,
		C_NO_INPUT,
		C_SQ_GT_N,
		C_DIV_MORE,
		C_REM_ZERO,
		C_OUT_BUSY
	} jmp_cond_t;

	typedef struct packed {
		dp_op_t    op;
		jmp_cond_t cond;
		pc_t       target;
	} ctrl_word_t;

	typedef struct packed {
		logic no_input;
		logic sq_gt_n;
		logic div_more;
		logic rem_zero;
		logic out_busy;
	} dp_status_t;

	typedef struct packed {
		logic [2:0] target_factors;
		logic [3:0] run_needed;
	} cfg_t;

	localparam pc_t ST_WAIT     = 3'd0;
	localparam pc_t ST_SQUARE   = 3'd1;
	localparam pc_t ST_TEST     = 3'd2;
	localparam pc_t ST_DIV_INIT = 3'd3;
	localparam pc_t ST_DIV_STEP = 3'd4;
	localparam pc_t ST_COMMIT   = 3'd5;
	localparam pc_t ST_NEXT_D   = 3'd6;
	localparam pc_t ST_FINISH   = 3'd7;

	// Microcode: a taken condition jumps to target, otherwise pc + 1.
	// FINISH is the last step; falling through wraps to WAIT.
	function automatic ctrl_word_t ucode_rom(pc_t pc);
		ctrl_word_t cw;
		case (pc)
			ST_WAIT:     cw = '{op: OP_LOAD,     cond: C_NO_INPUT, target: ST_WAIT};
			ST_SQUARE:   cw = '{op: OP_SQUARE,   cond: C_NEVER,    target: ST_WAIT};
			ST_TEST:     cw = '{op: OP_NOP,      cond: C_SQ_GT_N,  target: ST_FINISH};
			ST_DIV_INIT: cw = '{op: OP_DIV_INIT, cond: C_NEVER,    target: ST_WAIT};
			ST_DIV_STEP: cw = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: ST_DIV_STEP};
			ST_COMMIT:   cw = '{op: OP_COMMIT,   cond: C_REM_ZERO, target: ST_DIV_INIT};
			ST_NEXT_D:   cw = '{op: OP_NEXT_D,   cond: C_ALWAYS,   target: ST_SQUARE};
			ST_FINISH:   cw = '{op: OP_FINISH,   cond: C_OUT_BUSY, target: ST_FINISH};
			default:     cw = '{op: OP_NOP,      cond: C_ALWAYS,   target: ST_WAIT};
		endcase
		return cw;
	endfunction

endpackage

// ===== hw/rtl/dpfr_if.sv =====
// ----------------------------------------------------------------------------
// dpfr_if
// Valid/ready channels for the input numbers and the result items.
// ----------------------------------------------------------------------------
interface dpfr_in_if;
	logic                              valid;
	logic                              ready;
	logic [dpfr_pkg::NUMBER_WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

interface dpfr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] factor_count;
	logic [3:0] run_count;
	logic       hit;

	modport source (output valid, output factor_count, output run_count, output hit,
		input ready);
	modport sink   (input valid, input factor_count, input run_count, input hit,
		output ready);
endinterface

// ===== hw/rtl/dpfr_useq.sv =====
// ----------------------------------------------------------------------------
// dpfr_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module dpfr_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpfr_pkg::dp_status_t status,
	output dpfr_pkg::ctrl_word_t cw
);

	dpfr_pkg::pc_t pc_q;
	logic          take;

	always_comb begin
		cw = dpfr_pkg::ucode_rom(pc_q);
		case (cw.cond)
			dpfr_pkg::C_ALWAYS:   take = 1'b1;
			dpfr_pkg::C_NEVER:    take = 1'b0;
			dpfr_pkg::C_NO_INPUT: take = status.no_input;
			dpfr_pkg::C_SQ_GT_N:  take = status.sq_gt_n;
			dpfr_pkg::C_DIV_MORE: take = status.div_more;
			dpfr_pkg::C_REM_ZERO: take = status.rem_zero;
			dpfr_pkg::C_OUT_BUSY: take = status.out_busy;
			default:              take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dpfr_pkg::ST_WAIT;
		end else if (take) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + dpfr_pkg::pc_t'(1);
		end
	end

endmodule

// ===== hw/rtl/dpfr_datapath.sv =====
// ----------------------------------------------------------------------------
// dpfr_datapath
// Remainder, trial divisor, squarer, radix-2 divider, factor and run counters
// and the result register, all driven by the microcode word.
// ----------------------------------------------------------------------------
module dpfr_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpfr_pkg::ctrl_word_t cw,
	input  dpfr_pkg::cfg_t       cfg,
	output dpfr_pkg::dp_status_t status,
	dpfr_in_if.sink              in_ch,
	dpfr_out_if.source           out_ch
);

	localparam int W  = dpfr_pkg::NUMBER_WIDTH;
	localparam int DW = dpfr_pkg::DIV_WIDTH;
	localparam int SW = dpfr_pkg::SQ_WIDTH;
	localparam int BW = dpfr_pkg::BIT_CNT_WIDTH;

	logic [W-1:0]  n_q;
	logic [DW-1:0] d_q;
	logic [SW-1:0] sq_q;
	logic [W-1:0]  quo_q;
	logic [DW-1:0] rem_q;
	logic [BW-1:0] bit_q;
	logic [2:0]    cnt_q;
	logic          counted_q;
	logic [3:0]    run_q;
	logic          out_valid_q;
	logic [2:0]    out_cnt_q;
	logic [3:0]    out_run_q;
	logic          out_hit_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          trial_ge;
	logic [DW-1:0] rem_next;
	logic          out_busy;
	logic          load_fire;
	logic          finish_fire;
	logic [2:0]    fin_cnt;
	logic [3:0]    run_next;

	assign in_ch.ready = (cw.op == dpfr_pkg::OP_LOAD);
	assign load_fire   = in_ch.ready && in_ch.valid;
	assign out_busy    = out_valid_q && !out_ch.ready;
	assign finish_fire = (cw.op == dpfr_pkg::OP_FINISH) && !out_busy;

	// one quotient bit per cycle, dividend shifted out of quo_q from the top
	assign trial    = {rem_q, quo_q[W-1]};
	assign trial_ge = (trial >= {1'b0, d_q});
	assign diff     = trial - {1'b0, d_q};
	assign rem_next = trial_ge ? diff[DW-1:0] : trial[DW-1:0];

	// leftover remainder above one is a prime of its own
	always_comb begin
		fin_cnt = cnt_q;
		if (n_q > W'(1) && cnt_q != dpfr_pkg::COUNT_MAX) begin
			fin_cnt = cnt_q + 3'd1;
		end
		if (fin_cnt == cfg.target_factors) begin
			run_next = (run_q == dpfr_pkg::RUN_MAX) ? run_q : run_q + 4'd1;
		end else begin
			run_next = 4'd0;
		end
	end

	always_comb begin
		status.no_input = !in_ch.valid;
		status.sq_gt_n  = (sq_q > SW'(n_q));
		status.div_more = (bit_q != BW'(1));
		status.rem_zero = (rem_q == '0);
		status.out_busy = out_busy;
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			dpfr_pkg::OP_LOAD: begin
				if (load_fire) begin
					n_q   <= in_ch.number;
					d_q   <= DW'(2);
					cnt_q <= 3'd0;
					counted_q <= 1'b0;
				end
			end
			dpfr_pkg::OP_SQUARE: begin
				sq_q <= d_q * d_q;
			end
			dpfr_pkg::OP_DIV_INIT: begin
				quo_q <= n_q;
				rem_q <= '0;
				bit_q <= BW'(W);
			end
			dpfr_pkg::OP_DIV_STEP: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[W-2:0], trial_ge};
				bit_q <= bit_q - BW'(1);
			end
			dpfr_pkg::OP_COMMIT: begin
				if (rem_q == '0) begin
					n_q <= quo_q;
					counted_q <= 1'b1;
					if (!counted_q && cnt_q != dpfr_pkg::COUNT_MAX) begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
			end
			dpfr_pkg::OP_NEXT_D: begin
				d_q <= d_q + DW'(1);
				counted_q <= 1'b0;
			end
			dpfr_pkg::OP_FINISH: begin
				if (finish_fire) begin
					out_cnt_q <= fin_cnt;
					out_run_q <= run_next;
					out_hit_q <= (run_next == cfg.run_needed);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish_fire) begin
				run_q       <= run_next;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.factor_count = out_cnt_q;
	assign out_ch.run_count    = out_run_q;
	assign out_ch.hit          = out_hit_q;

endmodule

// ===== hw/rtl/distinct_prime_factor_run.sv =====
// ----------------------------------------------------------------------------
// distinct_prime_factor_run
// Counts distinct prime factors per item by trial division and tracks the
// run of consecutive items that have the target count.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    number[19:0]
//  out_ch   out  valid / ready    factor_count[2:0], run_count[3:0], hit
//  apb      in   psel / penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One item at a time. Each trial divisor d costs square + test + a 20-bit
// radix-2 division + commit + step, plus another division + commit for each
// extra division by a divisor that divides.
// A result waits in the output register; the next item is taken meanwhile.
// Reset clears the run counter and sets both registers to 4.
// ----------------------------------------------------------------------------
module distinct_prime_factor_run (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dpfr_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [dpfr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [dpfr_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	dpfr_in_if.sink                           in_ch,
	dpfr_out_if.source                        out_ch
);

	dpfr_pkg::cfg_t       cfg_q;
	dpfr_pkg::ctrl_word_t cw;
	dpfr_pkg::dp_status_t status;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_factors <= dpfr_pkg::TARGET_RESET;
			cfg_q.run_needed     <= dpfr_pkg::RUN_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				dpfr_pkg::REG_TARGET:     cfg_q.target_factors <= pwdata[2:0];
				dpfr_pkg::REG_RUN_NEEDED: cfg_q.run_needed     <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			dpfr_pkg::REG_TARGET:     prdata = {29'd0, cfg_q.target_factors};
			dpfr_pkg::REG_RUN_NEEDED: prdata = {28'd0, cfg_q.run_needed};
			default:                  prdata = '0;
		endcase
	end

	dpfr_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cw     (cw)
	);

	dpfr_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cw     (cw),
		.cfg    (cfg_q),
		.status (status),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule
